>>> rtl/pvsc_pkg.sv
`timescale 1ns / 1ps
// Package for the peak/valley step counter: word types, phase codes and constants.
// Depends on nothing; every other file of the block but pvsc_chan_if uses it.
package pvsc_pkg;

    localparam int unsigned LEVEL_W = 15;
    localparam int unsigned COUNT_W = 16;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [LEVEL_W-1:0] TICK_WRAP = 15'd30000;
    localparam logic [LEVEL_W-1:0] LEVEL_RESET = 15'd1500;
    localparam logic [LEVEL_W-1:0] AMP_THRESHOLD_RESET = 15'd2000;
    localparam logic [LEVEL_W-1:0] MIN_GAP_RESET = 15'd150;

    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_TICK = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] PHASE_NONE = 2'd0;
    localparam logic [1:0] PHASE_RISING = 2'd1;
    localparam logic [1:0] PHASE_FALLING = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_AMP_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP = 2'd1;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [LEVEL_W-1:0] accel_magnitude;
    } in_word_t;

    typedef struct packed {
        logic [COUNT_W-1:0] step_count;
        logic               step_detected;
    } out_word_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] reg_index;
        logic [LEVEL_W-1:0]   reg_data;
    } cfg_word_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] amplitude_threshold;
        logic [LEVEL_W-1:0] min_gap_ticks;
    } cfg_regs_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] previous_level;
        logic [LEVEL_W-1:0] valley_level;
        logic [1:0]         slope_phase;
        logic [LEVEL_W-1:0] gap_ticks;
        logic [COUNT_W-1:0] steps_total;
    } track_state_t;

endpackage

>>> rtl/pvsc_chan_if.sv
`timescale 1ns / 1ps
// Valid/ready channel carrying one word of a given payload type.
// Used with the word types of pvsc_pkg.
interface pvsc_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/pvsc_cfg_regs.sv
`timescale 1ns / 1ps
// Configuration registers of the step counter, written through a valid/ready channel.
// Depends on pvsc_pkg and pvsc_chan_if.
module pvsc_cfg_regs (
    input  logic                   clk,
    input  logic                   rst_n,
    pvsc_chan_if.sink              cfg,
    output pvsc_pkg::cfg_regs_t    regs
);
    pvsc_pkg::cfg_regs_t regs_reg;

    assign cfg.ready = 1'b1;
    assign regs = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.amplitude_threshold <= pvsc_pkg::AMP_THRESHOLD_RESET;
            regs_reg.min_gap_ticks <= pvsc_pkg::MIN_GAP_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.payload.reg_index)
                pvsc_pkg::REG_AMP_THRESHOLD:
                begin
                    regs_reg.amplitude_threshold <= cfg.payload.reg_data;
                end
                pvsc_pkg::REG_MIN_GAP:
                begin
                    regs_reg.min_gap_ticks <= cfg.payload.reg_data;
                end
                default:
                begin
                    // Writes beyond the register list are dropped.
                end
            endcase
        end
    end
endmodule

>>> rtl/pvsc_step_logic.sv
`timescale 1ns / 1ps
// Combinational update of the tracking state for one input word, and its result word.
// Depends on pvsc_pkg.
module pvsc_step_logic #(
    parameter logic [pvsc_pkg::LEVEL_W-1:0] TICK_WRAP = pvsc_pkg::TICK_WRAP
) (
    input  pvsc_pkg::track_state_t state,
    input  pvsc_pkg::cfg_regs_t    regs,
    input  pvsc_pkg::in_word_t     word,
    output pvsc_pkg::track_state_t state_next,
    output pvsc_pkg::out_word_t    result
);
    logic [pvsc_pkg::LEVEL_W:0]   valley_plus_thr;
    logic [pvsc_pkg::LEVEL_W:0]   gap_inc;
    logic                         swing_ok;
    logic                         gap_ok;
    logic                         counted;
    logic [pvsc_pkg::LEVEL_W-1:0] level;

    assign level = word.accel_magnitude;
    // Swing exceeds threshold exactly when the peak is above valley plus threshold.
    assign valley_plus_thr = {1'b0, state.valley_level} + {1'b0, regs.amplitude_threshold};
    assign swing_ok = {1'b0, state.previous_level} > valley_plus_thr;
    assign gap_ok = state.gap_ticks > regs.min_gap_ticks;
    assign gap_inc = {1'b0, state.gap_ticks} + 16'd1;

    always_comb
    begin
        state_next = state;
        counted = 1'b0;
        case (word.opcode)
            pvsc_pkg::OP_SAMPLE:
            begin
                if (state.previous_level < level)
                begin
                    if (state.slope_phase == pvsc_pkg::PHASE_FALLING)
                    begin
                        state_next.valley_level = state.previous_level;
                    end
                    state_next.previous_level = level;
                    state_next.slope_phase = pvsc_pkg::PHASE_RISING;
                end
                else if (state.previous_level > level)
                begin
                    if (state.slope_phase == pvsc_pkg::PHASE_RISING && swing_ok && gap_ok)
                    begin
                        state_next.steps_total = state.steps_total + 16'd1;
                        state_next.gap_ticks = '0;
                        counted = 1'b1;
                    end
                    state_next.previous_level = level;
                    state_next.slope_phase = pvsc_pkg::PHASE_FALLING;
                end
            end
            pvsc_pkg::OP_TICK:
            begin
                // The 16-bit sum also covers the 15-bit overflow, which is past the wrap.
                if (gap_inc >= {1'b0, TICK_WRAP})
                begin
                    state_next.gap_ticks = '0;
                end
                else
                begin
                    state_next.gap_ticks = gap_inc[pvsc_pkg::LEVEL_W-1:0];
                end
            end
            pvsc_pkg::OP_CLEAR:
            begin
                state_next.steps_total = '0;
            end
            default:
            begin
                // The unused opcode leaves the state alone.
            end
        endcase
        result.step_count = state_next.steps_total;
        result.step_detected = counted;
    end
endmodule

>>> rtl/peak_valley_step_counter_core.sv
`timescale 1ns / 1ps
// Peak/valley step counter: top level with input register, update logic and result register.
// Depends on pvsc_pkg, pvsc_chan_if, pvsc_cfg_regs and pvsc_step_logic.
//
// Usage:
// Each word on sample is a magnitude sample, a one millisecond tick or a clear
// of the step count. Every accepted word produces exactly one word on result,
// holding the step count after that input and a flag that is set when the input
// counted a new step.
// The cfg channel writes the amplitude threshold (index 0) and the minimum gap in
// ticks (index 1); it is always ready and should only be used while the block is idle.
// The result word is offered once it has passed the input register, loaded by the accepting
// edge, and then the result register, loaded through the update logic; a stalled result
// register keeps the word waiting in the input register.
// Throughput is one word per cycle while the receiver takes each result.
// When the receiver stalls, the result register holds its word and the input
// register fills; sample.ready then drops until the result is taken.
// Reset empties both registers, loads the default thresholds, and sets both the
// previous level and the valley to 1500, with no slope seen and zero counts.
module peak_valley_step_counter_core #(
    parameter logic [pvsc_pkg::LEVEL_W-1:0] TICK_WRAP = pvsc_pkg::TICK_WRAP
) (
    input  logic      clk,
    input  logic      rst_n,
    pvsc_chan_if.sink   sample,
    pvsc_chan_if.source result,
    pvsc_chan_if.sink   cfg
);
    pvsc_pkg::cfg_regs_t    regs;
    pvsc_pkg::track_state_t state_reg;
    pvsc_pkg::track_state_t state_next;
    pvsc_pkg::in_word_t     in_word_reg;
    pvsc_pkg::out_word_t    result_next;
    pvsc_pkg::out_word_t    out_word_reg;
    logic                   in_valid_reg;
    logic                   out_valid_reg;
    logic                   advance;

    pvsc_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    pvsc_step_logic #(
        .TICK_WRAP (TICK_WRAP)
    ) u_step_logic (
        .state      (state_reg),
        .regs       (regs),
        .word       (in_word_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    // The held word moves into the result register when that register is free
    // or is being emptied in the same cycle; the state is committed at that moment.
    assign advance = in_valid_reg && (!out_valid_reg || result.ready);
    assign sample.ready = !in_valid_reg || advance;

    assign result.valid = out_valid_reg;
    assign result.payload = out_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg.previous_level <= pvsc_pkg::LEVEL_RESET;
            state_reg.valley_level <= pvsc_pkg::LEVEL_RESET;
            state_reg.slope_phase <= pvsc_pkg::PHASE_NONE;
            state_reg.gap_ticks <= '0;
            state_reg.steps_total <= '0;
        end
        else
        begin
            if (sample.ready)
            begin
                in_valid_reg <= sample.valid;
            end
            if (advance)
            begin
                state_reg <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            in_word_reg <= sample.payload;
        end
        if (advance)
        begin
            out_word_reg <= result_next;
        end
    end

`ifndef SYNTHESIS
    // A counted step restarts the tick gap.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && result_next.step_detected |=> state_reg.gap_ticks == '0)
        else $error("gap ticks not restarted after a counted step");

    // While a result waits, no later word has changed the step count.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_word_reg.step_count == state_reg.steps_total)
        else $error("pending result does not match the step count");

    // An empty input register always takes a new word.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> sample.ready)
        else $error("input refused while the input register is empty");
`endif
endmodule
